/* hdl/caps_pkg.sv */
// Shared constants, codes and helpers for the constant-acceleration profile store.
// No dependencies; compiled first.
package caps_pkg;

  localparam int DATA_W     = 32;
  localparam int TIME_W     = 32;
  localparam int CMD_W      = 2;
  localparam int ORDER_W    = 2;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;

  localparam int DEF_MAX_POINTS = 64;
  localparam int DEF_FRAC_BITS  = 16;

  typedef logic signed [DATA_W-1:0] fix_t;
  typedef logic [TIME_W-1:0]        tstamp_t;

  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  localparam logic [ORDER_W-1:0] ORD_POS = 2'd0;
  localparam logic [ORDER_W-1:0] ORD_VEL = 2'd1;
  localparam logic [ORDER_W-1:0] ORD_ACC = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_BADQ  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_START_POS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_VEL = 1'd1;

  // clamp a 33-bit signed sum to 32 bits
  function automatic fix_t sat33(input logic signed [DATA_W:0] v);
    fix_t r;
    if (v[DATA_W] != v[DATA_W-1]) begin
      r = v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

/* hdl/caps_in_if.sv */
// Command channel: valid/ready plus one command beat.
// Depends on caps_pkg.
interface caps_in_if;
  logic                           valid;
  logic                           ready;
  logic [caps_pkg::CMD_W-1:0]     cmd;
  caps_pkg::fix_t                 accel;
  caps_pkg::tstamp_t              duration_step;
  caps_pkg::tstamp_t              query_time;
  logic [caps_pkg::ORDER_W-1:0]   order;

  modport source (output valid, cmd, accel, duration_step, query_time, order, input ready);
  modport sink   (input valid, cmd, accel, duration_step, query_time, order, output ready);
endinterface

/* hdl/caps_out_if.sv */
// Result channel: valid/ready plus one result beat.
// Depends on caps_pkg; CNT_W follows the stack depth.
interface caps_out_if #(
  parameter int CNT_W = $clog2(caps_pkg::DEF_MAX_POINTS + 1)
);
  logic                           valid;
  logic                           ready;
  caps_pkg::fix_t                 value;
  logic [caps_pkg::STATUS_W-1:0]  status;
  caps_pkg::tstamp_t              total_time;
  logic [CNT_W-1:0]               point_count;

  modport source (output valid, value, status, total_time, point_count, input ready);
  modport sink   (input valid, value, status, total_time, point_count, output ready);
endinterface

/* hdl/caps_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module caps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hdl/constant_accel_profile_store.sv */
// Top level of the constant-acceleration profile store.
// Depends on caps_pkg, caps_in_if, caps_out_if and caps_ram.
//
// Usage
//  - cmd_in carries one command per beat: push a segment (accel, duration_step),
//    pop the newest point, or query position/velocity/acceleration at query_time.
//  - res_out returns exactly one result beat per command: value, status,
//    total_time (time of the newest point) and point_count after the command.
//  - cfg_we/cfg_index/cfg_data write start_position (0) or start_velocity (1);
//    either write rebuilds the stack as the single start point. Write only idle.
// Timing
//  - One command at a time. Push runs the two multiplier passes (M1, M2).
//    Pop reads the new last point from RAM. Invalid query / full push / empty pop go straight to the result.
//    Query runs a binary search over the registered-read time RAM, then
//    fetches the segment and makes both passes through the shared multiplier.
//  - The result sits in an output register; the next command is taken while
//    it waits, and only that command's result stalls behind it.
// Storage
//  - Points 1..MAX_POINTS-1 live in two RAMs (time/position/velocity and
//    acceleration). Point 0 is held in registers, so no clear pass is needed.
//  - Reset (synchronous, rst) returns to one start point at position 0,
//    velocity 0; no command is in flight and res_out.valid drops.
module constant_accel_profile_store #(
  parameter int MAX_POINTS = caps_pkg::DEF_MAX_POINTS,
  parameter int FRAC_BITS  = caps_pkg::DEF_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [caps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [caps_pkg::DATA_W-1:0]    cfg_data,
  caps_in_if.sink                        cmd_in,
  caps_out_if.source                     res_out
);
  import caps_pkg::*;

  localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int PW    = 2 * DATA_W + 2;   // product width incl. headroom
  localparam int XW    = DATA_W + 2;       // multiplier operand width
  localparam logic [PW-1:0] MASK0 = (PW'(1) << FRAC_BITS) - PW'(1);
  localparam logic [PW-1:0] MASK1 = (PW'(1) << (FRAC_BITS + 1)) - PW'(1);
  localparam logic [PW-1:0] POS_LIM = PW'({1'b0, {(DATA_W-1){1'b1}}});
  localparam logic [PW-1:0] NEG_LIM = PW'({1'b1, {(DATA_W-1){1'b0}}});

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SRCH   = 4'd1;
  localparam logic [3:0] S_SRCHW  = 4'd2;
  localparam logic [3:0] S_FETCHW = 4'd3;
  localparam logic [3:0] S_M1A    = 4'd4;
  localparam logic [3:0] S_M1B    = 4'd5;
  localparam logic [3:0] S_M2A    = 4'd6;
  localparam logic [3:0] S_M2B    = 4'd7;
  localparam logic [3:0] S_POPW   = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0]          state;
  logic [CNT_W-1:0]    n;            // points held
  fix_t                start_pos, start_vel;
  tstamp_t             last_t;
  fix_t                last_s, last_v;

  // latched command
  logic                is_push;
  fix_t                accel_r;
  tstamp_t             qt_r;
  logic [ORDER_W-1:0]  order_r;

  // interpolation operands
  fix_t                s0, v0, a_op, v1;
  tstamp_t             dur;

  // search
  logic [AW-1:0]       lo, hi, mid_r;
  logic [AW:0]         mid_sum;
  logic [AW-1:0]       mid, k_idx;

  // result being built and output register
  fix_t                res_value;
  logic [STATUS_W-1:0] res_status;
  logic                out_valid;
  fix_t                out_value;
  logic [STATUS_W-1:0] out_status;
  tstamp_t             out_total;
  logic [CNT_W-1:0]    out_count;

  // RAM ports
  logic [AW-1:0]       rd_addr, ard_addr, wr_addr;
  logic                ram_we, rd_zero;
  logic [3*DATA_W-1:0] tsv_wdata, tsv_rdata;
  fix_t                acc_rdata;
  tstamp_t             t_rd;
  fix_t                s_rd, v_rd;

  // multiplier
  logic signed [XW-1:0] mul_x;
  logic [XW-1:0]        mag;
  logic [2*DATA_W-1:0]  prod_lo;
  logic                 prod_hi, neg_r, half_r;
  logic [PW-1:0]        full, q, qc;
  logic                 rem;
  fix_t                 mul_res, pos_sum, s1;
  tstamp_t              t1;
  logic [TIME_W:0]      t_sum;

  assign cmd_in.ready        = (state == S_IDLE);
  assign res_out.valid       = out_valid;
  assign res_out.value       = out_value;
  assign res_out.status      = out_status;
  assign res_out.total_time  = out_total;
  assign res_out.point_count = out_count;

  caps_ram #(.WIDTH(3 * DATA_W), .DEPTH(MAX_POINTS)) u_tsv_ram (
    .clk(clk), .we(ram_we), .waddr(wr_addr), .wdata(tsv_wdata),
    .raddr(rd_addr), .rdata(tsv_rdata)
  );

  caps_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_acc_ram (
    .clk(clk), .we(ram_we), .waddr(wr_addr), .wdata(accel_r),
    .raddr(ard_addr), .rdata(acc_rdata)
  );

  // search arithmetic
  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[AW:1];
  assign k_idx   = (lo == '0) ? '0 : lo - AW'(1);

  always_comb begin
    rd_addr  = k_idx;
    ard_addr = k_idx + AW'(1);
    if (state == S_IDLE) begin
      rd_addr = AW'(n - CNT_W'(2));   // new last point on pop
    end else if (state == S_SRCH && lo < hi) begin
      rd_addr = mid;
    end
  end

  // point 0 is not in RAM
  assign t_rd = rd_zero ? '0 : tsv_rdata[3*DATA_W-1:2*DATA_W];
  assign s_rd = rd_zero ? start_pos : tsv_rdata[2*DATA_W-1:DATA_W];
  assign v_rd = rd_zero ? start_vel : tsv_rdata[DATA_W-1:0];

  // multiplier front: magnitude of a 34-bit operand times a 32-bit duration
  always_comb begin
    if (state == S_M2A) begin
      mul_x = XW'(v0) + XW'(v1);
    end else begin
      mul_x = XW'(a_op);
    end
    mag = mul_x[XW-1] ? XW'(0) - XW'(mul_x) : XW'(mul_x);
  end

  // multiplier back: add upper partial product, floor shift, saturate
  always_comb begin
    full = PW'(prod_lo) + (prod_hi ? PW'({dur, {DATA_W{1'b0}}}) : '0);
    q    = half_r ? (full >> (FRAC_BITS + 1)) : (full >> FRAC_BITS);
    rem  = half_r ? |(full & MASK1) : |(full & MASK0);
    qc   = q + PW'(neg_r && rem);
    if (!neg_r) begin
      mul_res = (qc > POS_LIM) ? fix_t'(POS_LIM[DATA_W-1:0]) : fix_t'(qc[DATA_W-1:0]);
    end else begin
      mul_res = (qc > NEG_LIM) ? fix_t'(NEG_LIM[DATA_W-1:0])
                               : fix_t'(DATA_W'(0) - qc[DATA_W-1:0]);
    end
    pos_sum = sat33({s0[DATA_W-1], s0} + {mul_res[DATA_W-1], mul_res});
    s1      = (pos_sum < s0) ? s0 : pos_sum;
    t_sum   = {1'b0, last_t} + {1'b0, dur};
    t1      = t_sum[TIME_W] ? '1 : t_sum[TIME_W-1:0];
  end

  assign ram_we    = (state == S_M2B) && is_push;
  assign wr_addr   = AW'(n);
  assign tsv_wdata = {t1, s1, v1};

  always_ff @(posedge clk) begin
    rd_zero <= (rd_addr == '0);
    if (state == S_M1A || state == S_M2A) begin
      prod_lo <= mag[DATA_W-1:0] * dur;
      prod_hi <= mag[DATA_W];
      neg_r   <= mul_x[XW-1];
      half_r  <= (state == S_M2A);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      n         <= CNT_W'(1);
      start_pos <= '0;
      start_vel <= '0;
      last_t    <= '0;
      last_s    <= '0;
      last_v    <= '0;
      out_valid <= 1'b0;
    end else begin
      // drain the output register unless a new result replaces it this edge
      if (out_valid && res_out.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_START_POS: begin
            start_pos <= cfg_data;
            last_s    <= cfg_data;
            last_v    <= start_vel;
          end
          CFG_START_VEL: begin
            start_vel <= cfg_data;
            last_s    <= start_pos;
            last_v    <= cfg_data;
          end
          default: ;
        endcase
        n      <= CNT_W'(1);
        last_t <= '0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_in.valid) begin
            is_push    <= (cmd_in.cmd == CMD_PUSH);
            accel_r    <= cmd_in.accel;
            qt_r       <= cmd_in.query_time;
            order_r    <= cmd_in.order;
            res_value  <= '0;
            case (cmd_in.cmd)
              CMD_PUSH: begin
                if (n >= CNT_W'(MAX_POINTS)) begin
                  res_status <= STAT_FULL;
                  state      <= S_DONE;
                end else begin
                  res_status <= STAT_OK;
                  s0    <= last_s;
                  v0    <= last_v;
                  a_op  <= cmd_in.accel;
                  dur   <= cmd_in.duration_step;
                  state <= S_M1A;
                end
              end
              CMD_POP: begin
                if (n > CNT_W'(1)) begin
                  res_status <= STAT_OK;
                  n     <= n - CNT_W'(1);
                  state <= S_POPW;
                end else begin
                  res_status <= STAT_EMPTY;
                  state      <= S_DONE;
                end
              end
              default: begin   // query; the spare code also queries
                if (n < CNT_W'(2) || cmd_in.query_time > last_t) begin
                  res_status <= STAT_BADQ;
                  state      <= S_DONE;
                end else begin
                  res_status <= STAT_OK;
                  lo    <= '0;
                  hi    <= AW'(n - CNT_W'(1));
                  state <= S_SRCH;
                end
              end
            endcase
          end
        end
        S_SRCH: begin
          // count of stored times below query_time among points 0..n-2
          if (lo < hi) begin
            mid_r <= mid;
            state <= S_SRCHW;
          end else begin
            state <= S_FETCHW;
          end
        end
        S_SRCHW: begin
          if (t_rd < qt_r) begin
            lo <= mid_r + AW'(1);
          end else begin
            hi <= mid_r;
          end
          state <= S_SRCH;
        end
        S_FETCHW: begin
          s0    <= s_rd;
          v0    <= v_rd;
          a_op  <= acc_rdata;
          dur   <= qt_r - t_rd;
          state <= S_M1A;
        end
        S_M1A: state <= S_M1B;
        S_M1B: begin
          v1    <= sat33({v0[DATA_W-1], v0} + {mul_res[DATA_W-1], mul_res});
          state <= S_M2A;
        end
        S_M2A: state <= S_M2B;
        S_M2B: begin
          if (is_push) begin
            last_t <= t1;
            last_s <= s1;
            last_v <= v1;
            n      <= n + CNT_W'(1);
          end else begin
            case (order_r)
              ORD_POS: res_value <= pos_sum;
              ORD_VEL: res_value <= v1;
              ORD_ACC: res_value <= a_op;
              default: res_value <= '0;
            endcase
          end
          state <= S_DONE;
        end
        S_POPW: begin
          last_t <= t_rd;
          last_s <= s_rd;
          last_v <= v_rd;
          state  <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || res_out.ready) begin
            out_valid  <= 1'b1;
            out_value  <= res_value;
            out_status <= res_status;
            out_total  <= last_t;
            out_count  <= n;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // stack depth stays within 1..MAX_POINTS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (n != '0) && (n <= CNT_W'(MAX_POINTS)))
    else $error("point count out of range");

  // a push only writes a free slot
  a_write_free: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (n < CNT_W'(MAX_POINTS)))
    else $error("write past end of stack");

  // search window never inverts
  a_search_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_SRCH || state == S_SRCHW) |-> (lo <= hi))
    else $error("search window inverted");

  // a result is loaded only from the finishing state
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("result loaded outside finish");
endmodule
